FILE: design/pdlp_pkg.sv
`timescale 1ns / 1ps

package pdlp_pkg;

    // default sizes
    localparam int CHUNKS_DEF    = 65536;
    localparam int PID_SLOTS_DEF = 256;

    // field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 16;
    localparam int PID_W     = 22;
    localparam int FAC_W     = 16;
    localparam int RES_W     = 17;
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 64;
    localparam int CFG_IDX_W = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCESS   = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_PID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_FAC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FAC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_FAC  = 3'd4;

    // factors used when a factor register holds zero
    localparam logic [FAC_W-1:0] FAC_PRIO_DEF = 16'd1;
    localparam logic [FAC_W-1:0] FAC_LOW_DEF  = 16'd10;
    localparam logic [FAC_W-1:0] FAC_DEF_DEF  = 16'd5;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        K_IGNORE,
        K_ACTIVATE,
        K_ACCESS,
        K_EVICT
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   idx;
        logic [PID_W-1:0]   pid;
        logic [FAC_W-1:0]   factor;
    } work_t;

endpackage

FILE: design/pdlp_item_if.sv
`timescale 1ns / 1ps

interface pdlp_item_if;
    logic                          valid;
    logic                          ready;
    logic [pdlp_pkg::OP_W-1:0]     opcode;
    logic [pdlp_pkg::IDX_W-1:0]    chunk_index;
    logic [pdlp_pkg::PID_W-1:0]    proc_id;

    modport source (output valid, opcode, chunk_index, proc_id, input ready);
    modport sink (input valid, opcode, chunk_index, proc_id, output ready);
endinterface

FILE: design/pdlp_result_if.sv
`timescale 1ns / 1ps

interface pdlp_result_if;
    logic                          valid;
    logic                          ready;
    logic                          bypass_default;
    logic                          move_to_tail;
    logic                          pid_tracked;
    logic [pdlp_pkg::RES_W-1:0]    resident_chunks;
    logic [pdlp_pkg::CNT_W-1:0]    total_activations;
    logic [pdlp_pkg::CNT_W-1:0]    total_accesses;
    logic [pdlp_pkg::CNT_W-1:0]    promotions_allowed;
    logic [pdlp_pkg::CNT_W-1:0]    promotions_denied;

    modport source (output valid, bypass_default, move_to_tail, pid_tracked,
                    resident_chunks, total_activations, total_accesses,
                    promotions_allowed, promotions_denied, input ready);
    modport sink (input valid, bypass_default, move_to_tail, pid_tracked,
                  resident_chunks, total_activations, total_accesses,
                  promotions_allowed, promotions_denied, output ready);
endinterface

FILE: design/pdlp_cfg_if.sv
`timescale 1ns / 1ps

interface pdlp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pdlp_pkg::CFG_IDX_W-1:0]    index;
    logic [pdlp_pkg::PID_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pdlp_front.sv
`timescale 1ns / 1ps

module pdlp_front #(
    parameter int CHUNKS = pdlp_pkg::CHUNKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pdlp_item_if.sink         item,
    pdlp_cfg_if.sink          cfg,
    input  logic              clr_busy,
    input  logic              q_full,
    output logic              q_push,
    output pdlp_pkg::work_t   q_wdata
);

    logic [pdlp_pkg::PID_W-1:0] prio_pid_reg, prio_pid_next;
    logic [pdlp_pkg::PID_W-1:0] low_pid_reg, low_pid_next;
    logic [pdlp_pkg::FAC_W-1:0] prio_fac_reg, prio_fac_next;
    logic [pdlp_pkg::FAC_W-1:0] low_fac_reg, low_fac_next;
    logic [pdlp_pkg::FAC_W-1:0] def_fac_reg, def_fac_next;
    logic                       in_range;

    assign cfg.ready  = 1'b1;
    assign item.ready = !clr_busy && !q_full;
    assign q_push     = item.valid && item.ready;

    always_comb
    begin
        prio_pid_next = prio_pid_reg;
        low_pid_next  = low_pid_reg;
        prio_fac_next = prio_fac_reg;
        low_fac_next  = low_fac_reg;
        def_fac_next  = def_fac_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                pdlp_pkg::REG_PRIO_PID: prio_pid_next = cfg.data;
                pdlp_pkg::REG_LOW_PID:  low_pid_next  = cfg.data;
                pdlp_pkg::REG_PRIO_FAC: prio_fac_next = cfg.data[pdlp_pkg::FAC_W-1:0];
                pdlp_pkg::REG_LOW_FAC:  low_fac_next  = cfg.data[pdlp_pkg::FAC_W-1:0];
                pdlp_pkg::REG_DEF_FAC:  def_fac_next  = cfg.data[pdlp_pkg::FAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_pid_reg <= '0;
            low_pid_reg  <= '0;
            prio_fac_reg <= '0;
            low_fac_reg  <= '0;
            def_fac_reg  <= '0;
        end
        else
        begin
            prio_pid_reg <= prio_pid_next;
            low_pid_reg  <= low_pid_next;
            prio_fac_reg <= prio_fac_next;
            low_fac_reg  <= low_fac_next;
            def_fac_reg  <= def_fac_next;
        end
    end

    // classify the word and pick its decay factor
    assign in_range = (32'(item.chunk_index) < 32'(CHUNKS));

    always_comb
    begin
        q_wdata.idx = item.chunk_index;
        q_wdata.pid = item.proc_id;
        case (item.opcode)
            pdlp_pkg::OP_ACTIVATE: q_wdata.kind = pdlp_pkg::K_ACTIVATE;
            pdlp_pkg::OP_ACCESS:   q_wdata.kind = pdlp_pkg::K_ACCESS;
            pdlp_pkg::OP_EVICT:    q_wdata.kind = pdlp_pkg::K_EVICT;
            default:               q_wdata.kind = pdlp_pkg::K_IGNORE;
        endcase
        if (!in_range)
        begin
            q_wdata.kind = pdlp_pkg::K_IGNORE;
        end
        if (prio_pid_reg != '0 && item.proc_id == prio_pid_reg)
        begin
            q_wdata.factor = (prio_fac_reg != '0) ? prio_fac_reg : pdlp_pkg::FAC_PRIO_DEF;
        end
        else if (low_pid_reg != '0 && item.proc_id == low_pid_reg)
        begin
            q_wdata.factor = (low_fac_reg != '0) ? low_fac_reg : pdlp_pkg::FAC_LOW_DEF;
        end
        else
        begin
            q_wdata.factor = (def_fac_reg != '0) ? def_fac_reg : pdlp_pkg::FAC_DEF_DEF;
        end
    end

endmodule

FILE: design/pdlp_queue.sv
`timescale 1ns / 1ps

module pdlp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pdlp_pkg::work_t   wdata,
    output logic              full,
    input  logic              pop,
    output pdlp_pkg::work_t   rdata,
    output logic              empty
);

    localparam int PW = (pdlp_pkg::Q_DEPTH > 1) ? $clog2(pdlp_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(pdlp_pkg::Q_DEPTH + 1);

    pdlp_pkg::work_t entries_reg [pdlp_pkg::Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    assign full  = (count_reg == NW'(pdlp_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(pdlp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(pdlp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue popped while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

FILE: design/pdlp_back.sv
`timescale 1ns / 1ps

module pdlp_back #(
    parameter int CHUNKS    = pdlp_pkg::CHUNKS_DEF,
    parameter int PID_SLOTS = pdlp_pkg::PID_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pdlp_pkg::work_t   q_rdata,
    output logic              q_pop,
    output logic              clr_busy,
    pdlp_result_if.source     result
);

    localparam int CW = $clog2(CHUNKS);
    localparam int SW = $clog2(PID_SLOTS);
    localparam int DW = $clog2(pdlp_pkg::TOT_W) + 1;

    typedef struct packed {
        logic                          active;
        logic [pdlp_pkg::TOT_W-1:0]    total;
        logic [pdlp_pkg::PID_W-1:0]    owner;
    } chunk_t;

    typedef struct packed {
        logic [pdlp_pkg::RES_W-1:0]    res;
        logic [pdlp_pkg::CNT_W-1:0]    act;
        logic [pdlp_pkg::CNT_W-1:0]    acc;
        logic [pdlp_pkg::CNT_W-1:0]    allow;
        logic [pdlp_pkg::CNT_W-1:0]    deny;
    } slot_t;

    typedef struct packed {
        logic                          bypass_default;
        logic                          move_to_tail;
        logic                          pid_tracked;
        slot_t                         stats;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHRD, S_CHCHK, S_SCAN, S_SDRD, S_UPD, S_DIV, S_WB, S_FIN
    } state_t;

    function automatic logic [pdlp_pkg::CNT_W-1:0] sat_inc(input logic [pdlp_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // memories
    chunk_t                      chunk_mem [CHUNKS];
    logic [pdlp_pkg::PID_W-1:0]  tag_mem [PID_SLOTS];
    slot_t                       slot_mem [PID_SLOTS];

    chunk_t                      ch_q;
    logic [pdlp_pkg::PID_W-1:0]  tag_q;
    slot_t                       sd_q;

    logic                        ch_we;
    logic [CW-1:0]               ch_wa;
    logic [CW-1:0]               ch_ra;
    chunk_t                      ch_wd;
    logic                        tag_we;
    logic [SW-1:0]               tag_ra;
    logic                        sd_we;
    logic [SW-1:0]               sd_ra;

    // control and work registers
    state_t                      state_reg, state_next;
    logic [CW-1:0]               clr_cnt_reg;
    pdlp_pkg::work_t             wk_reg;
    logic                        act_reg;
    logic [pdlp_pkg::TOT_W-1:0]  tot_reg;
    logic [pdlp_pkg::PID_W-1:0]  own_reg;
    logic [pdlp_pkg::PID_W-1:0]  pid_reg;
    logic [SW:0]                 issue_reg;
    logic                        chk_vld_reg;
    logic [SW-1:0]               chk_idx_reg;
    logic                        found_reg;
    logic [SW-1:0]               slot_reg;
    logic                        free_vld_reg;
    logic [SW-1:0]               free_reg;
    logic                        trk_reg;
    logic                        byp_reg;
    logic                        move_reg;
    slot_t                       sd_reg;
    logic [pdlp_pkg::TOT_W-1:0]  dvd_reg;
    logic [pdlp_pkg::FAC_W-1:0]  rem_reg;
    logic [DW-1:0]               step_reg;
    logic [PID_SLOTS-1:0]        valid_reg;
    result_t                     out_reg;
    logic                        out_vld_reg;

    logic [pdlp_pkg::TOT_W-1:0]  cnt_inc;
    logic [pdlp_pkg::FAC_W:0]    div_trial;
    logic [pdlp_pkg::FAC_W:0]    div_sub;
    logic                        div_ge;
    logic                        alloc;
    logic                        slot_hit;
    slot_t                       sd_upd;
    logic                        trk_upd;

    assign clr_busy = (state_reg == S_CLEAR);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign cnt_inc  = tot_reg + 64'd1;
    assign div_trial = {rem_reg, dvd_reg[pdlp_pkg::TOT_W-1]};
    assign div_sub  = div_trial - {1'b0, wk_reg.factor};
    assign div_ge   = (div_trial >= {1'b0, wk_reg.factor});
    assign alloc    = (wk_reg.kind == pdlp_pkg::K_ACTIVATE) && !act_reg && !found_reg
                      && free_vld_reg;
    assign slot_hit = chk_vld_reg && valid_reg[chk_idx_reg] && (tag_q == pid_reg);

    // memory port control
    always_comb
    begin
        ch_we  = 1'b0;
        ch_wa  = CW'(wk_reg.idx);
        ch_wd  = '0;
        ch_ra  = CW'(wk_reg.idx);
        tag_we = 1'b0;
        tag_ra = issue_reg[SW-1:0];
        sd_we  = (state_reg == S_WB) && trk_reg;
        sd_ra  = found_reg ? slot_reg : free_reg;
        if (state_reg == S_CLEAR)
        begin
            ch_we = 1'b1;
            ch_wa = clr_cnt_reg;
        end
        else if (state_reg == S_UPD)
        begin
            case (wk_reg.kind)
                pdlp_pkg::K_ACTIVATE:
                begin
                    ch_we  = !act_reg;
                    ch_wd  = '{active: 1'b1, total: tot_reg, owner: pid_reg};
                    tag_we = alloc;
                end
                pdlp_pkg::K_ACCESS:
                begin
                    ch_we = 1'b1;
                    ch_wd = '{active: act_reg, total: cnt_inc, owner: own_reg};
                end
                pdlp_pkg::K_EVICT:
                begin
                    ch_we = 1'b1;
                    ch_wd = '{active: 1'b0, total: '0, owner: own_reg};
                end
                default: ;
            endcase
        end
    end

    // slot statistics after the word's update
    always_comb
    begin
        sd_upd  = sd_q;
        trk_upd = found_reg;
        case (wk_reg.kind)
            pdlp_pkg::K_ACTIVATE:
            begin
                if (!act_reg && found_reg)
                begin
                    sd_upd.res = (sd_q.res == '1) ? sd_q.res : sd_q.res + 1'b1;
                    sd_upd.act = sat_inc(sd_q.act);
                end
                else if (alloc)
                begin
                    trk_upd = 1'b1;
                    sd_upd  = '{res: 17'd1, act: 32'd1, default: '0};
                end
            end
            pdlp_pkg::K_ACCESS:
            begin
                sd_upd.acc = sat_inc(sd_q.acc);
            end
            pdlp_pkg::K_EVICT:
            begin
                if (sd_q.res != '0)
                begin
                    sd_upd.res = sd_q.res - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chunk_mem[ch_wa] <= ch_wd;
        end
        ch_q <= chunk_mem[ch_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[free_reg] <= pid_reg;
        end
        tag_q <= tag_mem[tag_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sd_we)
        begin
            slot_mem[slot_reg] <= sd_reg;
        end
        sd_q <= slot_mem[sd_ra];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == CW'(CHUNKS - 1)) state_next = S_IDLE;
            S_IDLE:  if (!q_empty) state_next = S_CHRD;
            S_CHRD:  state_next = (wk_reg.kind == pdlp_pkg::K_IGNORE) ? S_FIN : S_CHCHK;
            S_CHCHK:
            begin
                case (wk_reg.kind)
                    pdlp_pkg::K_EVICT: state_next = ch_q.active ? S_SCAN : S_FIN;
                    default:           state_next = (wk_reg.pid != '0) ? S_SCAN : S_FIN;
                endcase
            end
            S_SCAN:
            begin
                if (slot_hit || (!chk_vld_reg && issue_reg == (SW+1)'(PID_SLOTS)))
                begin
                    state_next = S_SDRD;
                end
            end
            S_SDRD:  state_next = S_UPD;
            S_UPD:   state_next = (wk_reg.kind == pdlp_pkg::K_ACCESS) ? S_DIV : S_WB;
            S_DIV:   if (step_reg == DW'(pdlp_pkg::TOT_W)) state_next = S_WB;
            S_WB:    state_next = S_FIN;
            S_FIN:   if (!out_vld_reg || result.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != S_FIN && result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    wk_reg <= q_rdata;
                end
                S_CHRD:
                begin
                    trk_reg      <= 1'b0;
                    byp_reg      <= 1'b0;
                    move_reg     <= 1'b0;
                    found_reg    <= 1'b0;
                    free_vld_reg <= 1'b0;
                    sd_reg       <= '0;
                end
                S_CHCHK:
                begin
                    act_reg     <= ch_q.active;
                    tot_reg     <= ch_q.total;
                    own_reg     <= ch_q.owner;
                    pid_reg     <= (wk_reg.kind == pdlp_pkg::K_EVICT) ? ch_q.owner : wk_reg.pid;
                    issue_reg   <= '0;
                    chk_vld_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    if (issue_reg != (SW+1)'(PID_SLOTS))
                    begin
                        issue_reg   <= issue_reg + 1'b1;
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= issue_reg[SW-1:0];
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (slot_hit)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= chk_idx_reg;
                    end
                    else if (chk_vld_reg && !valid_reg[chk_idx_reg] && !free_vld_reg)
                    begin
                        free_vld_reg <= 1'b1;
                        free_reg     <= chk_idx_reg;
                    end
                end
                S_UPD:
                begin
                    trk_reg <= trk_upd;
                    sd_reg  <= sd_upd;
                    case (wk_reg.kind)
                        pdlp_pkg::K_ACTIVATE:
                        begin
                            if (alloc)
                            begin
                                valid_reg[free_reg] <= 1'b1;
                                slot_reg            <= free_reg;
                            end
                        end
                        pdlp_pkg::K_ACCESS:
                        begin
                            byp_reg    <= 1'b1;
                            dvd_reg    <= cnt_inc;
                            rem_reg    <= '0;
                            step_reg   <= '0;
                        end
                        default: ;
                    endcase
                end
                S_DIV:
                begin
                    if (step_reg == DW'(pdlp_pkg::TOT_W))
                    begin
                        move_reg <= (rem_reg == '0);
                        if (rem_reg == '0)
                        begin
                            sd_reg.allow <= sat_inc(sd_reg.allow);
                        end
                        else
                        begin
                            sd_reg.deny <= sat_inc(sd_reg.deny);
                        end
                    end
                    else
                    begin
                        rem_reg  <= div_ge ? div_sub[pdlp_pkg::FAC_W-1:0]
                                           : div_trial[pdlp_pkg::FAC_W-1:0];
                        dvd_reg  <= {dvd_reg[pdlp_pkg::TOT_W-2:0], 1'b0};
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (!out_vld_reg || result.ready)
                    begin
                        out_vld_reg            <= 1'b1;
                        out_reg.bypass_default <= byp_reg;
                        out_reg.move_to_tail   <= move_reg;
                        out_reg.pid_tracked    <= trk_reg;
                        out_reg.stats          <= trk_reg ? sd_reg : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign result.valid              = out_vld_reg;
    assign result.bypass_default     = out_reg.bypass_default;
    assign result.move_to_tail       = out_reg.move_to_tail;
    assign result.pid_tracked        = out_reg.pid_tracked;
    assign result.resident_chunks    = out_reg.stats.res;
    assign result.total_activations  = out_reg.stats.act;
    assign result.total_accesses     = out_reg.stats.acc;
    assign result.promotions_allowed = out_reg.stats.allow;
    assign result.promotions_denied  = out_reg.stats.deny;

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("work taken during clearing pass");
    a_move_needs_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (!out_reg.move_to_tail || out_reg.bypass_default))
        else $error("move without bypass");
    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.pid_tracked) |-> (out_reg.stats == '0))
        else $error("untracked result carries statistics");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg <= DW'(pdlp_pkg::TOT_W)))
        else $error("divider ran past its steps");

endmodule

FILE: design/pid_decay_lru_promotion_filter.sv
`timescale 1ns / 1ps
// flow: an ignored word and a no-op word go straight to the result; activate, evict and
//   access first scan the pid tags, and access then divides its 64-bit total by the factor
// processing: one word at a time in the back end; the pid tag scan (one slot a cycle,
//   stops at a hit) and the remainder unit are the slow steps, the queue hides input stalls
// reset: asynchronous, active low; then a clearing pass sweeps every chunk table entry,
//   during which item.ready stays low (configuration writes are still taken)
module pid_decay_lru_promotion_filter #(
    parameter int CHUNKS    = pdlp_pkg::CHUNKS_DEF,
    parameter int PID_SLOTS = pdlp_pkg::PID_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    pdlp_item_if.sink      item,
    pdlp_cfg_if.sink       cfg,
    pdlp_result_if.source  result
);

    // front to queue
    logic             q_push;
    pdlp_pkg::work_t  q_wdata;
    logic             q_full;

    // queue to back
    logic             q_pop;
    pdlp_pkg::work_t  q_rdata;
    logic             q_empty;

    // back end sweeping the chunk table after reset
    logic             clr_busy;

    // front: takes words, holds the config registers, tags each word with its kind
    // and decay factor
    pdlp_front #(
        .CHUNKS (CHUNKS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .clr_busy (clr_busy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // short queue so the front keeps taking words while the back is busy
    pdlp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // back: chunk table, pid slot scan, remainder unit and the result register
    pdlp_back #(
        .CHUNKS    (CHUNKS),
        .PID_SLOTS (PID_SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .clr_busy (clr_busy),
        .result   (result)
    );

endmodule
